// ===== hw/rtl/trial_division_prime_test_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the trial division prime test
// Concurrent check wrappers; they compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

`ifndef SYNTHESIS
// check a property with reset masking it out
`define TDPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tdpt check failed");
// check a property that must also hold across reset
`define TDPT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tdpt check failed");
`else
`define TDPT_ASSERT(label, clk, rst, prop)
`define TDPT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/tdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// Trial division prime test package
// Shared widths, constants, sequencer states and inter-module structs.
// ---------------------------------------------------------------------------
package tdpt_pkg;

   localparam int NUM_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

   localparam logic [NUM_WIDTH-1:0] SMALLEST_PRIME = NUM_WIDTH'(2);
   localparam logic [NUM_WIDTH-1:0] FIRST_DIVISOR  = NUM_WIDTH'(3);
   localparam logic [NUM_WIDTH-1:0] DIVISOR_STEP   = NUM_WIDTH'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCREEN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_REPORT
   } seq_state_type;

   // sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // divider to sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
      logic quo_below;
   } div_stat_type;

   // sequencer to top level
   typedef struct packed {
      logic busy;
      logic fin;
      logic verdict;
   } seq_stat_type;

endpackage

// ===== hw/rtl/tdpt_divider.sv =====
// ---------------------------------------------------------------------------
// Bit-serial restoring divider
// Shifts one dividend bit per cycle into the partial remainder and one
// quotient bit out; NUM_WIDTH steps per division.
// ---------------------------------------------------------------------------
module tdpt_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  tdpt_pkg::div_ctrl_type          ctrl,
   input  logic [tdpt_pkg::NUM_WIDTH-1:0]  dividend,
   input  logic [tdpt_pkg::NUM_WIDTH-1:0]  divisor,
   output tdpt_pkg::div_stat_type          stat
);

   logic                            run_ff;
   logic                            done_ff;
   logic [tdpt_pkg::CNT_WIDTH-1:0]  cnt_ff;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  rem_ff;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  rem_in;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  quo_ff;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  quo_in;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  dvs_ff;
   logic [tdpt_pkg::NUM_WIDTH:0]    trial;
   logic [tdpt_pkg::NUM_WIDTH:0]    diff;
   logic                            fits;
   logic                            last_step;

   always_comb begin
      trial     = {rem_ff, quo_ff[tdpt_pkg::NUM_WIDTH-1]};
      diff      = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
      rem_in    = fits ? diff[tdpt_pkg::NUM_WIDTH-1:0] : trial[tdpt_pkg::NUM_WIDTH-1:0];
      quo_in    = {quo_ff[tdpt_pkg::NUM_WIDTH-2:0], fits};
      last_step = (cnt_ff == tdpt_pkg::CNT_WIDTH'(tdpt_pkg::NUM_WIDTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && last_step;
         if (ctrl.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.done      = done_ff;
   assign stat.rem_zero  = (rem_ff == '0);
   assign stat.quo_below = (quo_ff < dvs_ff);

endmodule

// ===== hw/rtl/tdpt_seq.sv =====
// ---------------------------------------------------------------------------
// Trial division sequencer
// Screens small and even numbers, then steps odd divisors through the
// divider until the quotient drops below the divisor or a remainder is zero.
// ---------------------------------------------------------------------------
module tdpt_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tdpt_pkg::NUM_WIDTH-1:0]  candidate,
   input  tdpt_pkg::div_stat_type          div_stat,
   output tdpt_pkg::div_ctrl_type          div_ctrl,
   output logic [tdpt_pkg::NUM_WIDTH-1:0]  dividend,
   output logic [tdpt_pkg::NUM_WIDTH-1:0]  divisor,
   output tdpt_pkg::seq_stat_type          stat
);

   tdpt_pkg::seq_state_type          state_ff;
   tdpt_pkg::seq_state_type          state_in;
   logic [tdpt_pkg::NUM_WIDTH-1:0]   cand_ff;
   logic [tdpt_pkg::NUM_WIDTH-1:0]   cand_in;
   logic [tdpt_pkg::NUM_WIDTH-1:0]   dvs_ff;
   logic [tdpt_pkg::NUM_WIDTH-1:0]   dvs_in;
   logic                             verdict_ff;
   logic                             verdict_in;
   logic                             below_two;
   logic                             is_two;

   assign below_two = (cand_ff[tdpt_pkg::NUM_WIDTH-1:1] == '0);
   assign is_two    = (cand_ff == tdpt_pkg::SMALLEST_PRIME);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tdpt_pkg::ST_SCREEN;
            end
         end
         tdpt_pkg::ST_SCREEN: begin
            if (below_two || is_two || !cand_ff[0]) begin
               state_in = tdpt_pkg::ST_REPORT;
            end else begin
               state_in = tdpt_pkg::ST_DIV_START;
            end
         end
         tdpt_pkg::ST_DIV_START: begin
            state_in = tdpt_pkg::ST_DIV_WAIT;
         end
         tdpt_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (div_stat.quo_below || div_stat.rem_zero) begin
                  state_in = tdpt_pkg::ST_REPORT;
               end else begin
                  state_in = tdpt_pkg::ST_DIV_START;
               end
            end
         end
         tdpt_pkg::ST_REPORT: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cand_in    = cand_ff;
      dvs_in     = dvs_ff;
      verdict_in = verdict_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            cand_in = candidate;
         end
         tdpt_pkg::ST_SCREEN: begin
            dvs_in     = tdpt_pkg::FIRST_DIVISOR;
            verdict_in = is_two;
         end
         tdpt_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               dvs_in = dvs_ff + tdpt_pkg::DIVISOR_STEP;
               // loop bound passes before the remainder counts
               verdict_in = div_stat.quo_below;
            end
         end
         default: begin
            cand_in = cand_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      div_ctrl.start = (state_ff == tdpt_pkg::ST_DIV_START);
      stat.busy      = (state_ff != tdpt_pkg::ST_IDLE);
      stat.fin       = (state_ff == tdpt_pkg::ST_REPORT);
      stat.verdict   = verdict_ff;
      dividend       = cand_ff;
      divisor        = dvs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      dvs_ff     <= dvs_in;
      verdict_ff <= verdict_in;
   end

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// ---------------------------------------------------------------------------
// Trial division prime test
// Answers one prime/not-prime flag for each unsigned number started.
// ---------------------------------------------------------------------------
// Raise start with a number on req_candidate while busy is low; the number is
// taken at that edge and busy rises. Exactly one result beat follows: rsp_valid
// is high for a single cycle with rsp_is_prime, and the receiver cannot hold it
// off, so sample it when it shows. 0, 1 and even numbers are settled by the
// screen without the divider. Odd numbers go through a bit-serial divider that
// retires one quotient bit per cycle for each trial divisor 3, 5, 7 and so on,
// and the test stops at the first zero remainder or once the quotient falls
// below the divisor; a 32-bit prime near the top of the range tries about 2^15
// divisors. busy drops in the cycle the result beat is shown, so a new start
// can be taken in that same cycle.
// ---------------------------------------------------------------------------
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [tdpt_pkg::NUM_WIDTH-1:0]  req_candidate,
   output logic                            rsp_valid,
   output logic                            rsp_is_prime
);

   tdpt_pkg::div_ctrl_type          div_ctrl;
   tdpt_pkg::div_stat_type          div_stat;
   tdpt_pkg::seq_stat_type          seq_stat;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  dividend;
   logic [tdpt_pkg::NUM_WIDTH-1:0]  divisor;
   logic                            rsp_valid_ff;
   logic                            rsp_is_prime_ff;

   // sequencer: screens the number and walks the odd divisors
   tdpt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .candidate (req_candidate),
      .div_stat  (div_stat),
      .div_ctrl  (div_ctrl),
      .dividend  (dividend),
      .divisor   (divisor),
      .stat      (seq_stat)
   );

   // divider: one quotient bit per cycle
   tdpt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .stat     (div_stat)
   );

   // register the result beat; strobe for one cycle only
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= seq_stat.fin;
      end
   end

   // hold the flag from the report cycle
   always_ff @(posedge clock) begin
      if (seq_stat.fin) begin
         rsp_is_prime_ff <= seq_stat.verdict;
      end
   end

   assign busy         = seq_stat.busy;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // an accepted start keeps the block busy in the next cycle
   `TDPT_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy)
   // a result beat only follows work, and the block is free while it shows
   `TDPT_ASSERT(a_rsp_after_work, clock, reset, rsp_valid |-> ($past(busy) && !busy))
   // the divider finishes only while the sequencer waits for it
   `TDPT_ASSERT(a_div_done_wait, clock, reset, div_stat.done |-> (busy && !seq_stat.fin))
   // reset leaves no work and no pending beat
   `TDPT_ASSERT_ALWAYS(a_reset_clean, clock, reset |=> (!busy && !rsp_valid))

endmodule

// ===== sim/trial_division_prime_test_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Trial division prime test bench
// Sends numbers to the prime tester and checks each one-cycle verdict beat
// against a trial-division predictor kept in the bench, first on directed
// corner numbers and then on random numbers under changing sender gaps.
// ---------------------------------------------------------------------------
module trial_division_prime_test_test;

   typedef logic [tdpt_pkg::NUM_WIDTH-1:0] number_type;

   // cycles to let pass after the last verdict before closing the run
   localparam int DRAIN_CYCLES = 64;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   number_type req_candidate;
   logic       rsp_valid;
   logic       rsp_is_prime;

   // verdicts predicted for accepted numbers, oldest first
   bit         expected_verdicts[$];
   number_type pending_numbers[$];
   int         error_count = 0;
   // chance in a hundred that the sender idles again before sending
   int         sender_idle_pct = 0;

   trial_division_prime_test i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Trial division: 0 and 1 are not prime, 2 is, other evens are not; for
   // odd numbers try each odd divisor d while d <= n / d, so the bound never
   // needs a product that could overflow.
   function automatic bit primality_of(input number_type value);
      longint unsigned n;
      longint unsigned d;
      n = longint'(value);
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Send one number: idle at random first, then hold start with the number
   // until busy is seen low at an edge, which is the edge that takes the beat.
   // Leave start high afterwards so a following number goes out back to back.
   task automatic send_candidate(input number_type value);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start         <= 1'b0;
         req_candidate <= number_type'($urandom);
         @(posedge clock);
      end
      start         <= 1'b1;
      req_candidate <= value;
      do @(posedge clock); while (busy);
      expected_verdicts = {expected_verdicts, primality_of(value)};
      pending_numbers   = {pending_numbers, value};
   endtask

   // Check every verdict beat; the receiver cannot stall, so take each one
   // in the cycle it shows and compare it with the oldest prediction.
   always @(posedge clock) begin
      bit         want;
      number_type number;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict beat, expected none, actual %0b",
                     $time, rsp_is_prime);
            error_count++;
         end else begin
            want   = expected_verdicts.pop_front();
            number = pending_numbers.pop_front();
            if (rsp_is_prime !== want) begin
               $display("%0t: is_prime of %0d: expected %0b, actual %0b",
                        $time, number, want, rsp_is_prime);
               error_count++;
            end
         end
      end
   end

   // Settle the cases that need no divider: zero, one, two and even numbers,
   // with the even extremes of the field.
   task automatic test_screened_values;
      send_candidate(number_type'(0));
      send_candidate(number_type'(1));
      send_candidate(number_type'(2));
      send_candidate(number_type'(4));
      send_candidate(number_type'(6));
      send_candidate({1'b1, {(tdpt_pkg::NUM_WIDTH-1){1'b0}}});
      send_candidate({{(tdpt_pkg::NUM_WIDTH-1){1'b1}}, 1'b0});
   endtask

   // Drive the divider loop: small primes, the first odd composites and
   // exact squares of primes, where the last divisor tried sits right on
   // the d*d bound.
   task automatic test_divisor_bound;
      send_candidate(number_type'(3));
      send_candidate(number_type'(5));
      send_candidate(number_type'(7));
      send_candidate(number_type'(9));
      send_candidate(number_type'(15));
      send_candidate(number_type'(25));
      send_candidate(number_type'(23));
      send_candidate(number_type'(49));
      send_candidate(number_type'(121));
      send_candidate(number_type'(65521));
      send_candidate(number_type'(16752649));   // 4093 squared
      send_candidate(number_type'(16777213));   // prime just below 2^24
   endtask

   // Hit the all-ones number and two odd numbers with the top bit set; the first two
   // have a small factor and stop early, the last may run a long search.
   task automatic test_wide_extremes;
      send_candidate({tdpt_pkg::NUM_WIDTH{1'b1}});
      send_candidate({1'b1, {(tdpt_pkg::NUM_WIDTH-2){1'b0}}, 1'b1});
      send_candidate({2'b10, {(tdpt_pkg::NUM_WIDTH-2){1'b1}}});
   endtask

   // Random numbers: mostly small ones where primes are common and the loop
   // is short, some mid-sized ones that run the loop longer, and full-width
   // numbers with a small factor so every bit toggles without a long search.
   task automatic test_random_numbers(input int count, input int idle_pct);
      int         pick;
      number_type value;
      int unsigned factor;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         pick = $urandom_range(99, 0);
         if (pick < 10) begin
            value = number_type'($urandom_range(100, 0));
         end else if (pick < 65) begin
            value = number_type'($urandom_range(32'hFFFF, 0));
         end else if (pick < 80) begin
            value = number_type'($urandom_range(32'hF_FFFF, 32'h1_0000));
         end else if (pick < 88) begin
            value = number_type'({$urandom, 1'b0});
         end else begin
            case ($urandom_range(3, 0))
               0: factor = 3;
               1: factor = 5;
               2: factor = 7;
               default: factor = 11;
            endcase
            value = number_type'(factor * $urandom_range(32'hFFFF_FFFF / factor, 0));
         end
         send_candidate(value);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_candidate <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 11;
      test_screened_values();
      test_divisor_bound();
      test_wide_extremes();

      // walk the sender through light gaps, heavy gaps, then none
      test_random_numbers(26, 11);
      test_random_numbers(26, 87);
      test_random_numbers(26, 0);

      // drop start and drain the outstanding verdicts
      start <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: a run that has not finished by this time limit fails.
   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
